>>> design/bdr_pkg.sv
// bdr_pkg: shared constants, codes and types of the backward delta regression unit
// no dependencies; used by the interfaces and by every module of the block
`default_nettype none

package bdr_pkg;

  // sample width and derived widths
  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;  // difference of two samples
  localparam int SUM_W       = SAMPLE_BITS + 4;  // four-point weighted sum
  localparam int WIN_W       = 3;

  // window register reset and clamp limits
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(4);

  // divide by ten through a reciprocal, exact for every magnitude below 2**SUM_W
  localparam int DIV10_SHIFT = SUM_W + 4;
  localparam int RECIP_W     = DIV10_SHIFT - 3;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV10_RECIP =
    RECIP_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

  // saturation limits
  localparam logic signed [SAMPLE_BITS-1:0] SLOPE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SLOPE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // number of points used for one item
  typedef enum logic [1:0] {
    MODE_ONE   = 2'd0,
    MODE_TWO   = 2'd1,
    MODE_THREE = 2'd2,
    MODE_FOUR  = 2'd3
  } fit_mode_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // snapshot of one item and its history, taken when the item is accepted
  typedef struct packed {
    sample_t   x0;
    sample_t   x1;
    sample_t   x2;
    sample_t   x3;
    fit_mode_e mode;
  } snap_t;

endpackage

`default_nettype wire

>>> design/bdr_if.sv
// bdr_if: valid/ready channel interfaces of the backward delta regression unit
// depends on bdr_pkg
`default_nettype none

// input item channel
interface bdr_in_if;
  import bdr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    track_start;
  modport source (output valid, output sample, output track_start, input ready);
  modport sink   (input valid, input sample, input track_start, output ready);
endinterface

// result item channel
interface bdr_out_if;
  import bdr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t slope;
  logic    clipped;
  modport source (output valid, output slope, output clipped, input ready);
  modport sink   (input valid, input slope, input clipped, output ready);
endinterface

// window register write channel
interface bdr_cfg_if;
  import bdr_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/bdr_history.sv
// bdr_history: window register, sample history and track point count
// depends on bdr_pkg; builds the snapshot of each accepted item
`default_nettype none

module bdr_history (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_fire_i,
  input  wire bdr_pkg::sample_t        sample_i,
  input  wire                          track_start_i,
  input  wire                          cfg_fire_i,
  input  wire [bdr_pkg::WIN_W-1:0]     cfg_data_i,
  output bdr_pkg::snap_t               snap_o
);
  import bdr_pkg::*;

  logic [WIN_W-1:0] win_q;
  sample_t          past_q [3];
  logic [1:0]       seen_q;
  logic [1:0]       seen_d;
  logic [1:0]       seen_eff;
  logic [WIN_W-1:0] win_eff;
  logic [WIN_W-1:0] avail;
  logic [WIN_W-1:0] npts;
  fit_mode_e        mode;

  // track start drops the old history from the count
  assign seen_eff = track_start_i ? 2'd0 : seen_q;
  assign seen_d   = (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;

  // clamp window and limit it to the points on hand
  always_comb begin
    if (win_q < WIN_MIN) begin
      win_eff = WIN_MIN;
    end else if (win_q > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = win_q;
    end
    avail = {1'b0, seen_eff} + WIN_W'(1);
    npts  = (avail < win_eff) ? avail : win_eff;
  end

  // point count to fit mode
  always_comb begin
    case (npts)
      WIN_W'(2): mode = MODE_TWO;
      WIN_W'(3): mode = MODE_THREE;
      WIN_W'(4): mode = MODE_FOUR;
      default:   mode = MODE_ONE;
    endcase
  end

  assign snap_o = '{x0: sample_i, x1: past_q[0], x2: past_q[1], x3: past_q[2], mode: mode};

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_fire_i) begin
      win_q <= cfg_data_i;
    end
  end

  // history shift and point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_q[0] <= '0;
      past_q[1] <= '0;
      past_q[2] <= '0;
      seen_q    <= 2'd0;
    end else if (in_fire_i) begin
      past_q[2] <= past_q[1];
      past_q[1] <= past_q[0];
      past_q[0] <= sample_i;
      seen_q    <= seen_d;
    end
  end

  // a track start leaves exactly one point counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && track_start_i |=> seen_q == 2'd1)
    else $error("point count wrong after track start");

  // a first point never selects a multi-point fit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_start_i |-> snap_o.mode == MODE_ONE)
    else $error("track start did not select the one-point fit");

  // a window write lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire_i |=> win_q == $past(cfg_data_i))
    else $error("window register did not take the written value");

endmodule

`default_nettype wire

>>> design/bdr_slope.sv
// bdr_slope: least-squares slope of one snapshot, truncated and saturated
// depends on bdr_pkg; pure combinational logic between the two register stages
`default_nettype none

module bdr_slope (
  input  wire bdr_pkg::snap_t snap_i,
  output bdr_pkg::sample_t    slope_o,
  output logic                clipped_o
);
  import bdr_pkg::*;

  logic signed [DIFF_W-1:0] d01;
  logic signed [DIFF_W-1:0] d02;
  logic signed [DIFF_W-1:0] d02_adj;
  logic signed [DIFF_W-1:0] half;
  logic signed [SUM_W-1:0]  s0;
  logic signed [SUM_W-1:0]  s3;
  logic signed [SUM_W-1:0]  sum4;
  logic        [SUM_W-1:0]  mag;
  logic        [PROD_W-1:0] prod;
  logic        [SAMPLE_BITS-1:0] quot;
  sample_t                  tenth;
  logic                     d01_ovf;

  // two and three point differences
  assign d01 = DIFF_W'(snap_i.x0) - DIFF_W'(snap_i.x1);
  assign d02 = DIFF_W'(snap_i.x0) - DIFF_W'(snap_i.x2);

  // halve toward zero: bias negatives by one before the shift
  assign d02_adj = d02 + DIFF_W'(d02[DIFF_W-1]);
  assign half    = d02_adj >>> 1;

  // four point weighted sum 3*x0 + x1 - x2 - 3*x3
  assign s0   = SUM_W'(snap_i.x0);
  assign s3   = SUM_W'(snap_i.x3);
  assign sum4 = (s0 <<< 1) + s0 + SUM_W'(snap_i.x1) - SUM_W'(snap_i.x2) - (s3 <<< 1) - s3;

  // divide magnitude by ten with the reciprocal, then restore the sign
  assign mag   = sum4[SUM_W-1] ? SUM_W'(-sum4) : SUM_W'(sum4);
  assign prod  = {{RECIP_W{1'b0}}, mag} * {{SUM_W{1'b0}}, DIV10_RECIP};
  assign quot  = prod[DIV10_SHIFT +: SAMPLE_BITS];
  assign tenth = sum4[SUM_W-1] ? sample_t'(-quot) : sample_t'(quot);

  // only the two point slope can leave the sample range
  assign d01_ovf = d01[DIFF_W-1] != d01[DIFF_W-2];

  // select by fit mode
  always_comb begin
    clipped_o = 1'b0;
    case (snap_i.mode)
      MODE_TWO: begin
        if (d01_ovf) begin
          clipped_o = 1'b1;
          slope_o   = d01[DIFF_W-1] ? SLOPE_MIN : SLOPE_MAX;
        end else begin
          slope_o = d01[SAMPLE_BITS-1:0];
        end
      end
      MODE_THREE: slope_o = half[SAMPLE_BITS-1:0];
      MODE_FOUR:  slope_o = tenth;
      default:    slope_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/backward_delta_regression_unit.sv
// backward_delta_regression_unit: top level of the backward delta regression unit
// depends on bdr_pkg, bdr_if, bdr_history and bdr_slope
//
//   channel  dir  payload                 handshake
//   in_i     in   sample, track_start     valid/ready
//   out_o    out  slope, clipped          valid/ready
//   cfg_i    in   data (window_points)    valid/ready, ready always high
//
// An item is captured with its history into an input register, and its slope
// goes into the result register once that register is free; one item per cycle
// is sustained while out_o.ready stays high. Reset clears the history,
// the point count, the stage valid bits and sets the window to two points. A
// stalled result holds the input register; in_i.ready drops only while both
// stages are full and out_o.ready is low.
`default_nettype none

module backward_delta_regression_unit (
  input  wire clk_i,
  input  wire rst_ni,
  bdr_in_if.sink    in_i,
  bdr_cfg_if.sink   cfg_i,
  bdr_out_if.source out_o
);
  import bdr_pkg::*;

  logic    in_fire;
  logic    cfg_fire;
  logic    out_free;
  logic    s1_adv;
  snap_t   snap;
  logic    s1_valid_q;
  snap_t   s1_snap_q;
  sample_t slope;
  logic    clipped;
  logic    out_valid_q;
  sample_t out_slope_q;
  logic    out_clipped_q;

  // handshakes
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // history and window state
  bdr_history u_history (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .sample_i      (in_i.sample),
    .track_start_i (in_i.track_start),
    .cfg_fire_i    (cfg_fire),
    .cfg_data_i    (cfg_i.data),
    .snap_o        (snap)
  );

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_snap_q <= snap;
    end
  end

  // slope of the captured item
  bdr_slope u_slope (
    .snap_i    (s1_snap_q),
    .slope_o   (slope),
    .clipped_o (clipped)
  );

  // result register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_slope_q   <= slope;
      out_clipped_q <= clipped;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.slope   = out_slope_q;
  assign out_o.clipped = out_clipped_q;

  // a clipped result sits at one of the range limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clipped_q |-> out_slope_q == SLOPE_MAX || out_slope_q == SLOPE_MIN)
    else $error("clipped result not at a range limit");

  // a captured item stays while the result stage is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_snap_q))
    else $error("input stage item lost under stall");

  // input is refused only with the input stage occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q)
    else $error("input refused with free stages");

  // an advancing item always shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced item did not reach the result stage");

endmodule

`default_nettype wire
